// File: rtl/core/stw_pkg.sv
`timescale 1ns / 1ps

package stw_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ID_W      = 8;
  localparam int TICK_W    = 63;
  localparam int ENTRY_W   = ID_W + TICK_W;

  localparam logic [TICK_W-1:0] WAKE_MAX = {TICK_W{1'b1}};

  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// File: rtl/core/sleep_table_tick_wakeup_top.sv
`timescale 1ns / 1ps

// sleep table with next-expiry tracking
// input: an item is taken at a clock edge where start is high and busy is low.
//   cmd_i = sleep appends {thread_id_i, tick_value_i} to the table unless full,
//   cmd_i = tick wakes every entry with a wake tick at or before tick_value_i.
// output: each result is shown for exactly one cycle while out_valid_o is high;
//   the receiver cannot stall, so results are never held back.
// sleep: busy stays low, the single result appears in the next cycle, so a
//   sleep item can be taken every cycle.
// tick: the table memory is read one slot per cycle over count entries, with
//   registered read data and a closing step after the last one; kept entries
//   are written back compacted in the same pass and woken ids go to a second
//   memory. the woken ids are then read out one per cycle, so a tick holds busy
//   through the scan and the read-out; each result follows in the cycle after
//   its read, all carrying the recomputed next_wake_o.
// reset clears the entry count and sets next_wake to the maximum; the memories
//   need no clearing pass since only entries below the count are ever read.
module sleep_table_tick_wakeup_top #(
  parameter int SLOTS = stw_pkg::SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd_i,
  input  logic [stw_pkg::ID_W-1:0]  thread_id_i,
  input  logic [stw_pkg::TICK_W-1:0] tick_value_i,
  output logic                      out_valid_o,
  output logic                      woken_valid_o,
  output logic [stw_pkg::ID_W-1:0]  woken_id_o,
  output logic                      last_o,
  output logic [stw_pkg::TICK_W-1:0] next_wake_o,
  output logic                      status_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } st_e;

  st_e                        state_q;
  logic [CW-1:0]              cnt_q;
  logic [stw_pkg::TICK_W-1:0] earliest_q;
  logic [stw_pkg::TICK_W-1:0] tick_q;
  logic [stw_pkg::TICK_W-1:0] min_q;
  logic [CW-1:0]              rd_idx_q;
  logic                       rd_vld_q;
  logic [CW-1:0]              keep_q;
  logic [CW-1:0]              nwk_q;
  logic [IW-1:0]              em_idx_q;
  logic                       out_valid_q;
  logic                       out_wvalid_q;
  logic                       out_last_q;
  logic                       out_status_q;

  logic                        accept;
  logic                        slot_re;
  logic                        slot_we;
  logic [IW-1:0]               slot_waddr;
  logic [stw_pkg::ENTRY_W-1:0] slot_wdata;
  logic [stw_pkg::ENTRY_W-1:0] slot_rdata;
  logic [stw_pkg::ID_W-1:0]    rd_thread;
  logic [stw_pkg::TICK_W-1:0]  rd_wake;
  logic                        is_due;
  logic                        wk_we;
  logic                        wk_re;
  logic [stw_pkg::ID_W-1:0]    wk_rdata;
  logic                        scan_done;
  logic                        em_last;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign rd_thread = slot_rdata[stw_pkg::ENTRY_W-1:stw_pkg::TICK_W];
  assign rd_wake   = slot_rdata[stw_pkg::TICK_W-1:0];
  assign is_due    = (rd_wake <= tick_q);

  always_comb begin
    slot_re    = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
    scan_done  = (state_q == ST_SCAN) && !slot_re && !rd_vld_q;
    wk_we      = rd_vld_q && is_due;
    wk_re      = (state_q == ST_EMIT);
    em_last    = ({{(CW - IW){1'b0}}, em_idx_q} == CW'(nwk_q - CW'(1)));
    if (state_q == ST_SCAN) begin
      slot_we    = rd_vld_q && !is_due;
      slot_waddr = keep_q[IW-1:0];
      slot_wdata = slot_rdata;
    end else begin
      slot_we    = accept && (cmd_i == stw_pkg::CMD_SLEEP) && (cnt_q < SlotsC);
      slot_waddr = cnt_q[IW-1:0];
      slot_wdata = {thread_id_i, tick_value_i};
    end
  end

  stw_ram #(
    .Width(stw_pkg::ENTRY_W),
    .Depth(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (slot_re),
    .raddr_i(rd_idx_q[IW-1:0]),
    .rdata_o(slot_rdata)
  );

  stw_ram #(
    .Width(stw_pkg::ID_W),
    .Depth(SLOTS)
  ) u_woken_ram (
    .clk_i  (clk_i),
    .we_i   (wk_we),
    .waddr_i(nwk_q[IW-1:0]),
    .wdata_i(rd_thread),
    .re_i   (wk_re),
    .raddr_i(em_idx_q),
    .rdata_o(wk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      earliest_q   <= stw_pkg::WAKE_MAX;
      tick_q       <= '0;
      min_q        <= stw_pkg::WAKE_MAX;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      keep_q       <= '0;
      nwk_q        <= '0;
      em_idx_q     <= '0;
      out_valid_q  <= 1'b0;
      out_wvalid_q <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= stw_pkg::STATUS_OK;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_i == stw_pkg::CMD_SLEEP) begin
              if (cnt_q < SlotsC) begin
                cnt_q        <= CW'(cnt_q + CW'(1));
                out_status_q <= stw_pkg::STATUS_OK;
                if (tick_value_i < earliest_q) begin
                  earliest_q <= tick_value_i;
                end
              end else begin
                out_status_q <= stw_pkg::STATUS_FULL;
              end
              out_valid_q  <= 1'b1;
              out_wvalid_q <= 1'b0;
              out_last_q   <= 1'b1;
            end else begin
              tick_q   <= tick_value_i;
              min_q    <= stw_pkg::WAKE_MAX;
              rd_idx_q <= '0;
              rd_vld_q <= 1'b0;
              keep_q   <= '0;
              nwk_q    <= '0;
              state_q  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_vld_q <= slot_re;
          if (slot_re) begin
            rd_idx_q <= CW'(rd_idx_q + CW'(1));
          end
          if (rd_vld_q) begin
            if (is_due) begin
              nwk_q <= CW'(nwk_q + CW'(1));
            end else begin
              keep_q <= CW'(keep_q + CW'(1));
              if (rd_wake < min_q) begin
                min_q <= rd_wake;
              end
            end
          end
          if (scan_done) begin
            cnt_q      <= keep_q;
            earliest_q <= min_q;
            em_idx_q   <= '0;
            if (nwk_q == '0) begin
              out_valid_q  <= 1'b1;
              out_wvalid_q <= 1'b0;
              out_last_q   <= 1'b1;
              out_status_q <= stw_pkg::STATUS_OK;
              state_q      <= ST_IDLE;
            end else begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          em_idx_q     <= IW'(em_idx_q + IW'(1));
          out_valid_q  <= 1'b1;
          out_wvalid_q <= 1'b1;
          out_last_q   <= em_last;
          out_status_q <= stw_pkg::STATUS_OK;
          if (em_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign woken_valid_o = out_valid_q && out_wvalid_q;
  assign woken_id_o    = woken_valid_o ? wk_rdata : '0;
  assign last_o        = out_last_q;
  assign next_wake_o   = earliest_q;
  assign status_o      = out_status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SlotsC)
    else $error("entry count above table size");

  a_scan_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(keep_q + nwk_q) <= cnt_q))
    else $error("scan split exceeds entry count");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o) |-> (!woken_valid_o && last_o))
    else $error("rejected sleep result malformed");

  a_tick_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == stw_pkg::CMD_TICK)) |=> (state_q == ST_SCAN))
    else $error("tick item did not start a scan");

  a_sleep_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == stw_pkg::CMD_SLEEP)) |=> (out_valid_o && last_o && !busy))
    else $error("sleep item gave no result");

endmodule

// File: rtl/core/stw_ram.sv
`timescale 1ns / 1ps

module stw_ram #(
  parameter int Width = stw_pkg::ENTRY_W,
  parameter int Depth = stw_pkg::SLOTS_DEF,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sim/sleep_table_tick_wakeup_top_tb.sv
`timescale 1ns / 1ps

module sleep_table_tick_wakeup_top_tb;

  localparam int SLOTS      = stw_pkg::SLOTS_DEF;
  localparam int CYCLE_MAX  = 200000;
  localparam int TAIL_WAIT  = 2 * SLOTS + 8;
  localparam int RAND_ITEMS = 300;

  typedef struct packed {
    logic                       woken_valid;
    logic [stw_pkg::ID_W-1:0]   woken_id;
    logic                       last;
    logic [stw_pkg::TICK_W-1:0] next_wake;
    logic                       status;
  } wake_result_t;

  class wake_scoreboard;
    logic [stw_pkg::ID_W-1:0]   sleeper_ids[$];
    logic [stw_pkg::TICK_W-1:0] sleeper_ticks[$];
    logic [stw_pkg::TICK_W-1:0] earliest;
    wake_result_t               expected_q[$];
    int                         errors;

    function new();
      earliest = stw_pkg::WAKE_MAX;
      errors   = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void note_item(logic cmd, logic [stw_pkg::ID_W-1:0] id,
                            logic [stw_pkg::TICK_W-1:0] tick);
      logic                       st;
      logic [stw_pkg::ID_W-1:0]   woken[$];
      logic [stw_pkg::ID_W-1:0]   kept_ids[$];
      logic [stw_pkg::TICK_W-1:0] kept_ticks[$];
      logic [stw_pkg::TICK_W-1:0] next;
      wake_result_t               res;
      if (cmd == stw_pkg::CMD_SLEEP) begin
        st = stw_pkg::STATUS_OK;
        if (sleeper_ids.size() >= SLOTS) begin
          st = stw_pkg::STATUS_FULL;
        end else begin
          sleeper_ids.push_back(id);
          sleeper_ticks.push_back(tick);
          if (tick < earliest) earliest = tick;
        end
        res = '{1'b0, '0, 1'b1, earliest, st};
        expected_q.push_back(res);
      end else begin
        next = stw_pkg::WAKE_MAX;
        foreach (sleeper_ids[i]) begin
          if (sleeper_ticks[i] <= tick) begin
            woken.push_back(sleeper_ids[i]);
          end else begin
            if (sleeper_ticks[i] < next) next = sleeper_ticks[i];
            kept_ids.push_back(sleeper_ids[i]);
            kept_ticks.push_back(sleeper_ticks[i]);
          end
        end
        sleeper_ids   = kept_ids;
        sleeper_ticks = kept_ticks;
        earliest      = next;
        if (woken.size() == 0) begin
          res = '{1'b0, '0, 1'b1, earliest, stw_pkg::STATUS_OK};
          expected_q.push_back(res);
        end else begin
          foreach (woken[i]) begin
            res = '{1'b1, woken[i], (i == woken.size() - 1), earliest,
                    stw_pkg::STATUS_OK};
            expected_q.push_back(res);
          end
        end
      end
    endfunction

    task check_result(logic wv, logic [stw_pkg::ID_W-1:0] id, logic lst,
                      logic [stw_pkg::TICK_W-1:0] nw, logic st);
      wake_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: valid %0b id %0d", wv, id));
      end else begin
        exp = expected_q.pop_front();
        if (wv !== exp.woken_valid)
          report($sformatf("woken_valid %0b, want %0b", wv, exp.woken_valid));
        if (id !== exp.woken_id)
          report($sformatf("woken_id %0d, want %0d", id, exp.woken_id));
        if (lst !== exp.last)
          report($sformatf("last %0b, want %0b (id %0d)", lst, exp.last, exp.woken_id));
        if (nw !== exp.next_wake)
          report($sformatf("next_wake %0h, want %0h", nw, exp.next_wake));
        if (st !== exp.status)
          report($sformatf("status %0b, want %0b", st, exp.status));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic                       cmd_i;
  logic [stw_pkg::ID_W-1:0]   thread_id_i;
  logic [stw_pkg::TICK_W-1:0] tick_value_i;
  logic                       out_valid_o;
  logic                       woken_valid_o;
  logic [stw_pkg::ID_W-1:0]   woken_id_o;
  logic                       last_o;
  logic [stw_pkg::TICK_W-1:0] next_wake_o;
  logic                       status_o;

  wake_scoreboard             sb;
  int                         cycles;
  logic [stw_pkg::TICK_W-1:0] now_tick;

  sleep_table_tick_wakeup_top #(.SLOTS(SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .thread_id_i   (thread_id_i),
    .tick_value_i  (tick_value_i),
    .out_valid_o   (out_valid_o),
    .woken_valid_o (woken_valid_o),
    .woken_id_o    (woken_id_o),
    .last_o        (last_o),
    .next_wake_o   (next_wake_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("sleep_table_tick_wakeup_top_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o)
      sb.check_result(woken_valid_o, woken_id_o, last_o, next_wake_o, status_o);
  end

  function automatic logic [stw_pkg::TICK_W-1:0] any_tick();
    return stw_pkg::TICK_W'({$urandom, $urandom});
  endfunction

  // called at a falling edge; returns at a falling edge after the item is taken
  task automatic send_item(logic cmd, logic [stw_pkg::ID_W-1:0] id,
                           logic [stw_pkg::TICK_W-1:0] tick);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= cmd;
    thread_id_i  <= id;
    tick_value_i <= tick;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(cmd, id, tick);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int roll;
    logic cmd;
    logic [stw_pkg::TICK_W-1:0] tick;
    sb           = new();
    cycles       = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = stw_pkg::CMD_SLEEP;
    thread_id_i  = '0;
    tick_value_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, max wake tick, zero wake tick, fill, overflow, exact match, wake all
    send_item(stw_pkg::CMD_TICK, 8'd0, '0);
    send_item(stw_pkg::CMD_SLEEP, 8'd0, stw_pkg::WAKE_MAX);
    send_item(stw_pkg::CMD_SLEEP, 8'd255, '0);
    for (int i = 0; i < SLOTS - 2; i++)
      send_item(stw_pkg::CMD_SLEEP, stw_pkg::ID_W'($urandom_range(1, 254)),
                stw_pkg::TICK_W'(10 + i));
    send_item(stw_pkg::CMD_SLEEP, 8'd77, stw_pkg::TICK_W'(1));
    send_item(stw_pkg::CMD_TICK, 8'd255, '0);
    send_item(stw_pkg::CMD_SLEEP, 8'd128, any_tick());
    send_item(stw_pkg::CMD_TICK, 8'd0, stw_pkg::WAKE_MAX);
    drain_results();

    now_tick = stw_pkg::TICK_W'($urandom_range(0, 1000));
    for (int n = 0; n < RAND_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) drain_results();
      cmd = ($urandom_range(0, 99) < 58) ? stw_pkg::CMD_SLEEP : stw_pkg::CMD_TICK;
      if (roll == 99)
        now_tick = stw_pkg::WAKE_MAX - stw_pkg::TICK_W'($urandom_range(0, 3000));
      if (roll == 98) now_tick = stw_pkg::TICK_W'($urandom_range(0, 1000));
      if (cmd == stw_pkg::CMD_SLEEP) begin
        if (roll < 8) tick = any_tick();
        else if (roll < 11) tick = stw_pkg::WAKE_MAX;
        else tick = now_tick + stw_pkg::TICK_W'($urandom_range(0, 60));
      end else begin
        now_tick = now_tick + stw_pkg::TICK_W'($urandom_range(0, 25));
        tick = (roll < 6) ? any_tick() : now_tick;
      end
      send_item(cmd, stw_pkg::ID_W'($urandom_range(0, 255)), tick);
    end
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("sleep_table_tick_wakeup_top_tb: clean");
    else
      $display("sleep_table_tick_wakeup_top_tb: errors");
    $finish;
  end

endmodule
